@@ hdl/chxor_pkg.sv @@
// ----------------------------------------------------------------------------
// chxor_pkg
// Shared types, constants and helpers for the ChaCha20 stream XOR core.
// ----------------------------------------------------------------------------
package chxor_pkg;

    // sixteen 32-bit words of block state, word 0 in the low bits
    typedef logic [15:0][31:0] t_words;

    // configuration as held by the register file
    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_lo;
        logic [31:0]      nonce_hi;
        logic [31:0]      init_ctr;
        logic [63:0]      offset;
    } t_cfg;

    // register indexes
    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_INIT_CTR = 3'd6;
    localparam logic [2:0] REG_OFFSET   = 3'd7;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646E;
    localparam logic [31:0] SIGMA2 = 32'h79622D32;
    localparam logic [31:0] SIGMA3 = 32'h6B206574;

    // 10 double rounds, 8 quarter rounds each, 2 half steps per quarter round
    localparam int unsigned NUM_HALF_STEPS = 10 * 8 * 2;
    localparam logic [7:0]  LAST_STEP      = 8'(NUM_HALF_STEPS - 1);

    // initial block state from configuration and block counter
    function automatic t_words build_init(input t_cfg cfg, input logic [31:0] ctr);
        t_words w;
        w[0]  = SIGMA0;
        w[1]  = SIGMA1;
        w[2]  = SIGMA2;
        w[3]  = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            w[4 + 2 * i] = cfg.key[i][31:0];
            w[5 + 2 * i] = cfg.key[i][63:32];
        end
        w[12] = ctr;
        w[13] = cfg.nonce_lo[31:0];
        w[14] = cfg.nonce_lo[63:32];
        w[15] = cfg.nonce_hi;
        return w;
    endfunction

endpackage

@@ hdl/chxor_apb.sv @@
// ----------------------------------------------------------------------------
// chxor_apb
// APB register file: key, nonce, initial counter and stream offset.
// ----------------------------------------------------------------------------
module chxor_apb (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output chxor_pkg::t_cfg   o_cfg,
    output logic              o_cfg_wr
);

    chxor_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[5:3];
    assign wr_en    = psel && penable && pwrite;
    assign o_cfg    = r_cfg;
    assign o_cfg_wr = wr_en;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                chxor_pkg::REG_KEY0:     r_cfg.key[0]   <= pwdata;
                chxor_pkg::REG_KEY1:     r_cfg.key[1]   <= pwdata;
                chxor_pkg::REG_KEY2:     r_cfg.key[2]   <= pwdata;
                chxor_pkg::REG_KEY3:     r_cfg.key[3]   <= pwdata;
                chxor_pkg::REG_NONCE_LO: r_cfg.nonce_lo <= pwdata;
                chxor_pkg::REG_NONCE_HI: r_cfg.nonce_hi <= pwdata[31:0];
                chxor_pkg::REG_INIT_CTR: r_cfg.init_ctr <= pwdata[31:0];
                chxor_pkg::REG_OFFSET:   r_cfg.offset   <= pwdata;
                default:                 r_cfg          <= r_cfg;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            chxor_pkg::REG_KEY0:     prdata = r_cfg.key[0];
            chxor_pkg::REG_KEY1:     prdata = r_cfg.key[1];
            chxor_pkg::REG_KEY2:     prdata = r_cfg.key[2];
            chxor_pkg::REG_KEY3:     prdata = r_cfg.key[3];
            chxor_pkg::REG_NONCE_LO: prdata = r_cfg.nonce_lo;
            chxor_pkg::REG_NONCE_HI: prdata = {32'd0, r_cfg.nonce_hi};
            chxor_pkg::REG_INIT_CTR: prdata = {32'd0, r_cfg.init_ctr};
            chxor_pkg::REG_OFFSET:   prdata = r_cfg.offset;
            default:                 prdata = '0;
        endcase
    end

endmodule

@@ hdl/chxor_qhalf.sv @@
// ----------------------------------------------------------------------------
// chxor_qhalf
// Half of a ChaCha quarter round: two add-xor-rotate steps.
// ----------------------------------------------------------------------------
module chxor_qhalf (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic        i_second,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);

    logic [31:0] sum_a;
    logic [31:0] xor_d;
    logic [31:0] rot_d;
    logic [31:0] sum_c;
    logic [31:0] xor_b;
    logic [31:0] rot_b;

    // a += b; d ^= a; d <<<= 16 or 8
    assign sum_a = i_a + i_b;
    assign xor_d = i_d ^ sum_a;
    assign rot_d = i_second ? {xor_d[23:0], xor_d[31:24]} : {xor_d[15:0], xor_d[31:16]};

    // c += d; b ^= c; b <<<= 12 or 7
    assign sum_c = i_c + rot_d;
    assign xor_b = i_b ^ sum_c;
    assign rot_b = i_second ? {xor_b[24:0], xor_b[31:25]} : {xor_b[19:0], xor_b[31:20]};

    assign o_a = sum_a;
    assign o_b = rot_b;
    assign o_c = sum_c;
    assign o_d = rot_d;

endmodule

@@ hdl/chxor_block.sv @@
// ----------------------------------------------------------------------------
// chxor_block
// Keystream block generator: one half quarter round per cycle on a shared
// unit; keystream words read out with the final add.
// ----------------------------------------------------------------------------
module chxor_block (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chxor_pkg::t_cfg   i_cfg,
    input  logic              i_start,
    input  logic [31:0]       i_ctr,
    input  logic [3:0]        i_idx,
    output logic              o_done,
    output logic [31:0]       o_ks_word
);

    chxor_pkg::t_words r_w;
    chxor_pkg::t_words n_w;
    chxor_pkg::t_words init_w;
    chxor_pkg::t_words start_w;
    logic [31:0]       r_ctr;
    logic              r_busy;
    logic              r_done;
    logic [7:0]        r_step;

    logic [2:0]  qr_sel;
    logic [1:0]  lane;
    logic [1:0]  shift;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] qa, qb, qc, qd;

    // operand selection: column rounds then diagonal rounds
    assign qr_sel = r_step[3:1];
    assign lane   = qr_sel[1:0];
    assign shift  = qr_sel[2] ? 2'd1 : 2'd0;
    assign ia     = {2'b00, lane};
    assign ib     = {2'b01, 2'(lane + shift)};
    assign ic     = {2'b10, 2'(lane + 2'(shift << 1))};
    assign id     = {2'b11, 2'(lane + 2'(shift * 2'd3))};

    chxor_qhalf u_qhalf (
        .i_a      (r_w[ia]),
        .i_b      (r_w[ib]),
        .i_c      (r_w[ic]),
        .i_d      (r_w[id]),
        .i_second (r_step[0]),
        .o_a      (qa),
        .o_b      (qb),
        .o_c      (qc),
        .o_d      (qd)
    );

    assign start_w = chxor_pkg::build_init(i_cfg, i_ctr);
    assign init_w  = chxor_pkg::build_init(i_cfg, r_ctr);

    // load the start state or write back the four words of the quarter round
    always_comb begin
        n_w = r_w;
        if (i_start) begin
            n_w = start_w;
        end else if (r_busy) begin
            n_w[ia] = qa;
            n_w[ib] = qb;
            n_w[ic] = qc;
            n_w[id] = qd;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (i_start) begin
            r_ctr <= i_ctr;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == chxor_pkg::LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 8'd1;
            end
        end
    end

    // final add on read
    assign o_done    = r_done;
    assign o_ks_word = r_w[i_idx] + init_w[i_idx];

endmodule

@@ hdl/chacha20_stream_xor_core.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_xor_core
// ChaCha20 stream XOR, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a data byte, a begin flag and a last flag on a
//   valid/ready channel; output beats carry the XORed byte and the last flag.
//   Key, nonce, initial counter and stream offset are written through the
//   APB port, by the user only while the core is idle (the core does not
//   enforce it). A begin beat restarts the stream at the configured offset.
// Byte flow:
//   A byte inside the held keystream block is registered to the output in the
//   cycle after acceptance; the next byte may follow in the next cycle if the
//   output is taken. A begin beat, a byte at a 64-byte boundary or the first
//   byte after a register write starts a new block: the half quarter rounds
//   run on the shared round unit, then the byte is registered to the output.
// Reset:
//   Synchronous active-low reset clears the configuration registers, state,
//   position, block-held and output-valid flags; no clearing pass is needed.
// Stall:
//   The output register holds its beat while the receiver stalls, and the
//   input is not ready while that beat cannot be replaced.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_in,
    input  logic        i_begin_req,
    input  logic        i_last,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_out,
    output logic        o_last_out,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GEN,
        S_EMIT
    } t_fsm;

    chxor_pkg::t_cfg cfg;
    logic            cfg_wr;

    t_fsm        r_fsm, n_fsm;
    logic [63:0] r_pos, n_pos;
    logic        r_ks_valid, n_ks_valid;
    logic [7:0]  r_data, n_data;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data, n_out_data;
    logic        r_out_last, n_out_last;

    logic [63:0] pos_eff;
    logic        need_block;
    logic        out_free;
    logic        accept;
    logic        blk_start;
    logic        blk_done;
    logic [31:0] blk_ctr;
    logic [63:0] rd_pos;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    chxor_apb u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    chxor_block u_block (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_start   (blk_start),
        .i_ctr     (blk_ctr),
        .i_idx     (rd_pos[5:2]),
        .o_done    (blk_done),
        .o_ks_word (ks_word)
    );

    // position of this beat and whether a fresh block is due
    assign pos_eff    = i_begin_req ? cfg.offset : r_pos;
    assign need_block = i_begin_req || !r_ks_valid || (pos_eff[5:0] == 6'd0);
    assign blk_ctr    = cfg.init_ctr + pos_eff[37:6];

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_fsm == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign blk_start  = accept && need_block;

    // keystream byte select
    assign rd_pos  = (r_fsm == S_IDLE) ? pos_eff : r_pos;
    assign ks_byte = ks_word[{rd_pos[1:0], 3'b000} +: 8];

    // next-state logic
    always_comb begin
        n_fsm       = r_fsm;
        n_pos       = r_pos;
        n_ks_valid  = r_ks_valid;
        n_data      = r_data;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    if (need_block) begin
                        n_pos      = pos_eff;
                        n_data     = i_data_in;
                        n_last     = i_last;
                        n_ks_valid = 1'b0;
                        n_fsm      = S_GEN;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_data  = i_data_in ^ ks_byte;
                        n_out_last  = i_last;
                        n_pos       = pos_eff + 64'd1;
                    end
                end else if (cfg_wr) begin
                    n_ks_valid = 1'b0;
                end
            end
            S_GEN: begin
                if (blk_done) begin
                    n_ks_valid = 1'b1;
                    n_fsm      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ ks_byte;
                    n_out_last  = r_last;
                    n_pos       = r_pos + 64'd1;
                    n_fsm       = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_pos       <= '0;
            r_ks_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_pos       <= n_pos;
            r_ks_valid  <= n_ks_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_last_out  = r_out_last;

endmodule

@@ verif/tb_chacha20_stream_xor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_stream_xor_core
// Self-checking bench for the ChaCha20 stream XOR core. Byte beats go in
// through a queue-fed driver, every accepted beat is run through a local
// ChaCha20 keystream predictor, and each output beat is compared with the
// oldest predicted beat. Covers wrap of position and block counter, start
// beats, continuation without start, register writes that drop the held
// block, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_xor_core;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_BEATS   = 155;
    localparam int unsigned DRAIN_CYCLES  = 300;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       fin;
    } t_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_xor_beat;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_data  = 8'h00;
    logic        in_first = 1'b0;
    logic        in_fin   = 1'b0;
    logic        out_ready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_data_out;
    logic        o_last_out;
    logic [63:0] prdata;
    logic        pready;

    // stimulus and scoreboard storage
    t_beat       beat_q[$];
    t_xor_beat   xor_bytes_q[$];
    logic        in_taken = 1'b0;
    bit          quiet = 1'b0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;

    // predictor state
    logic [63:0]       cfg_reg [8] = '{default: '0};
    int unsigned       cfg_epoch = 0;
    int unsigned       ks_epoch = 0;
    logic [63:0]       stream_pos = '0;
    chxor_pkg::t_words ks_block;
    bit                ks_held = 1'b0;

    chacha20_stream_xor_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_in   (in_data),
        .i_begin_req (in_first),
        .i_last      (in_fin),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_data_out  (o_data_out),
        .o_last_out  (o_last_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // keystream predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic chxor_pkg::t_words quarter(input chxor_pkg::t_words w,
                                                  input int a, input int b,
                                                  input int c, input int d);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
        return w;
    endfunction

    function automatic chxor_pkg::t_words chacha_block(input logic [31:0] ctr);
        chxor_pkg::t_words start_w;
        chxor_pkg::t_words w;
        start_w[0] = chxor_pkg::SIGMA0;
        start_w[1] = chxor_pkg::SIGMA1;
        start_w[2] = chxor_pkg::SIGMA2;
        start_w[3] = chxor_pkg::SIGMA3;
        // eight key words, two per 64-bit register
        for (int k = 0; k < 8; k++)
            start_w[4 + k] = cfg_reg[k / 2][32 * (k % 2) +: 32];
        start_w[12] = ctr;
        start_w[13] = cfg_reg[chxor_pkg::REG_NONCE_LO][31:0];
        start_w[14] = cfg_reg[chxor_pkg::REG_NONCE_LO][63:32];
        start_w[15] = cfg_reg[chxor_pkg::REG_NONCE_HI][31:0];
        w = start_w;
        for (int r = 0; r < 10; r++) begin
            w = quarter(w, 0, 4, 8, 12);
            w = quarter(w, 1, 5, 9, 13);
            w = quarter(w, 2, 6, 10, 14);
            w = quarter(w, 3, 7, 11, 15);
            w = quarter(w, 0, 5, 10, 15);
            w = quarter(w, 1, 6, 11, 12);
            w = quarter(w, 2, 7, 8, 13);
            w = quarter(w, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++)
            w[k] = w[k] + start_w[k];
        return w;
    endfunction

    // xor one accepted byte with the keystream and advance the position
    function automatic t_xor_beat chacha_xor_byte(input t_beat b);
        logic [5:0] off;
        t_xor_beat  r;
        if (ks_epoch != cfg_epoch) begin
            ks_held  = 1'b0;
            ks_epoch = cfg_epoch;
        end
        if (b.first) begin
            stream_pos = cfg_reg[chxor_pkg::REG_OFFSET];
            ks_held    = 1'b0;
        end
        off = stream_pos[5:0];
        if (!ks_held || off == 6'd0) begin
            ks_block = chacha_block(cfg_reg[chxor_pkg::REG_INIT_CTR][31:0]
                                    + stream_pos[37:6]);
            ks_held  = 1'b1;
        end
        r.data = b.data ^ ks_block[off[5:2]][8 * off[1:0] +: 8];
        r.fin  = b.fin;
        stream_pos = stream_pos + 64'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endfunction

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_beat nxt;
        if (!in_valid || in_taken) begin
            if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end else if (beat_q.size() != 0) begin
                nxt = beat_q.pop_front();
                in_valid <= 1'b1;
                in_data  <= nxt.data;
                in_first <= nxt.first;
                in_fin   <= nxt.fin;
                in_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output ready: random stalls plus one long hold on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // prediction on input beats, check on output beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_xor_beat want;
        in_taken <= in_valid && o_in_ready;
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                xor_bytes_q.push_back(chacha_xor_byte(t_beat'({in_data, in_first, in_fin})));
            if (o_out_valid && out_ready) begin
                if (xor_bytes_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected output beat data %h last %b",
                                            o_data_out, o_last_out));
                end else begin
                    want = xor_bytes_q.pop_front();
                    if (o_data_out !== want.data)
                        flag_mismatch($sformatf("data expected %h actual %h",
                                                want.data, o_data_out));
                    if (o_last_out !== want.fin)
                        flag_mismatch($sformatf("last expected %b actual %b",
                                                want.fin, o_last_out));
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // narrow registers keep only their low word
        if (idx == chxor_pkg::REG_NONCE_HI || idx == chxor_pkg::REG_INIT_CTR)
            cfg_reg[idx] = {32'd0, val[31:0]};
        else
            cfg_reg[idx] = val;
        cfg_epoch = cfg_epoch + 1;
    endtask

    task automatic queue_beat(input logic [7:0] data, input logic first, input logic fin);
        t_beat b;
        b.data  = data;
        b.first = first;
        b.fin   = fin;
        beat_q.push_back(b);
    endtask

    task automatic queue_message(input int unsigned len, input bit with_first,
                                 input bit with_fin);
        for (int unsigned k = 0; k < len; k++)
            queue_beat(8'($urandom_range(0, 255)), with_first && k == 0,
                       with_fin && k == len - 1);
    endtask

    // mostly complete messages, some continuations, broken and one-beat ones
    task automatic queue_random_traffic(input int unsigned budget);
        int unsigned n;
        int unsigned len;
        int unsigned kind;
        n = 0;
        while (n < budget) begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 200)
                                                : $urandom_range(1, 20);
            if (kind < 75) begin
                queue_message(len, 1'b1, 1'b1);
            end else if (kind < 85) begin
                len = $urandom_range(1, 10);
                queue_message(len, 1'b0, 1'($urandom_range(0, 1)));
            end else if (kind < 95) begin
                queue_message(len, 1'b1, 1'b0);
            end else begin
                len = 1;
                queue_message(len, 1'b1, 1'b1);
            end
            n = n + len;
        end
    endtask

    function automatic logic [63:0] pick_offset();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 64'($urandom_range(0, 300));
        else if (r < 7)
            return 64'd0 - 64'($urandom_range(1, 200));
        else if (r < 8)
            return rand64() & ~64'd63;
        return rand64();
    endfunction

    task automatic program_random_config();
        logic [63:0] v;
        for (int i = chxor_pkg::REG_KEY0; i <= chxor_pkg::REG_OFFSET; i++) begin
            v = rand64();
            if (3'(i) == chxor_pkg::REG_INIT_CTR && $urandom_range(0, 3) == 0)
                v[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            if (3'(i) == chxor_pkg::REG_OFFSET)
                v = pick_offset();
            write_reg(3'(i), v);
        end
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || in_valid || xor_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, stream from position zero without a start beat,
        // then keep going after a last beat
        queue_beat(8'h00, 1'b0, 1'b0);
        queue_beat(8'hFF, 1'b0, 1'b0);
        queue_beat(8'h5A, 1'b0, 1'b1);
        queue_beat(8'hA5, 1'b0, 1'b0);
        wait_idle();

        // all-ones key, nonce and counter; offset just below position wrap,
        // so block counter and position both wrap
        for (int i = chxor_pkg::REG_KEY0; i < chxor_pkg::REG_OFFSET; i++)
            write_reg(3'(i), '1);
        write_reg(chxor_pkg::REG_OFFSET, 64'hFFFF_FFFF_FFFF_FFFD);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b0, 1'b0);
        queue_beat(8'h0F, 1'b0, 1'b0);
        queue_beat(8'hF0, 1'b0, 1'b1);
        queue_beat(8'h3C, 1'b0, 1'b0);
        queue_beat(8'hC3, 1'b1, 1'b1);
        wait_idle();

        // all-zero settings, message crossing a block boundary
        for (int i = chxor_pkg::REG_KEY0; i < chxor_pkg::REG_OFFSET; i++)
            write_reg(3'(i), '0);
        write_reg(chxor_pkg::REG_OFFSET, 64'd62);
        queue_beat(8'h11, 1'b1, 1'b0);
        queue_beat(8'h22, 1'b0, 1'b0);
        queue_beat(8'h33, 1'b0, 1'b0);
        queue_beat(8'h44, 1'b0, 1'b1);
        wait_idle();

        // key change mid block: next beat needs a fresh block
        write_reg(chxor_pkg::REG_KEY0, rand64());
        queue_beat(8'h55, 1'b0, 1'b0);
        queue_beat(8'h66, 1'b0, 1'b1);
        wait_idle();

        // random phases
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet = (p == 1);
            if (p == 3) begin
                write_reg(3'($urandom_range(chxor_pkg::REG_KEY0, chxor_pkg::REG_OFFSET)),
                          rand64());
                queue_message(5, 1'b0, 1'b0);
            end else begin
                program_random_config();
            end
            if (p == 2)
                hold_req = hold_req + 1;
            queue_random_traffic(PHASE_BEATS);
            wait_idle();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && xor_bytes_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/chxor_pkg.sv
hdl/chxor_apb.sv
hdl/chxor_qhalf.sv
hdl/chxor_block.sv
hdl/chacha20_stream_xor_core.sv
verif/tb_chacha20_stream_xor_core.sv
